// ===== rtl/core/mcis_pkg.sv =====
// Shared types and constants for the multichannel IIR sensor conditioner.
// Used by the filter update, the light level logic and the top level.
package mcis_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CHAN_W   = 2;
	localparam int GAIN_W   = 9;
	localparam int ACC_W    = 26;
	localparam int FILT_W   = 19;	// internal filtered value, before truncation to the port
	localparam int OUT_W    = 17;
	localparam int PCT_W    = 7;

	localparam logic [CHAN_W-1:0]   LIGHT_CHANNEL = 2'd2;
	localparam logic [GAIN_W-1:0]   GAIN_ONE      = 9'd256;
	localparam logic [PCT_W-1:0]    PCT_MAX       = 7'd100;

	// Configuration register indexes
	localparam logic [2:0] CFG_GAIN0     = 3'd0;
	localparam logic [2:0] CFG_GAIN1     = 3'd1;
	localparam logic [2:0] CFG_GAIN2     = 3'd2;
	localparam logic [2:0] CFG_DARK_TH   = 3'd3;
	localparam logic [2:0] CFG_LIGHT_OFS = 3'd4;
	localparam logic [2:0] CFG_LED_ON    = 3'd5;
	localparam logic [2:0] CFG_LED_OFF   = 3'd6;

	// Reset values of the configuration registers
	localparam logic [GAIN_W-1:0]   RST_GAIN0     = 9'd160;
	localparam logic [GAIN_W-1:0]   RST_GAIN1     = 9'd160;
	localparam logic [GAIN_W-1:0]   RST_GAIN2     = 9'd4;
	localparam logic [SAMPLE_W-1:0] RST_DARK_TH   = 16'hFFF0;
	localparam logic [PCT_W-1:0]    RST_LIGHT_OFS = 7'd20;
	localparam logic [PCT_W-1:0]    RST_LED_ON    = 7'd45;
	localparam logic [PCT_W-1:0]    RST_LED_OFF   = 7'd55;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain0;
		logic [GAIN_W-1:0]   gain1;
		logic [GAIN_W-1:0]   gain2;
		logic [SAMPLE_W-1:0] dark_th;
		logic [PCT_W-1:0]    light_ofs;
		logic [PCT_W-1:0]    led_on;
		logic [PCT_W-1:0]    led_off;
	} mcis_cfg_t;

endpackage

// ===== rtl/core/mcis_filter_step.sv =====
// One update of a channel accumulator: priming load or smoothing step.
// Depends on mcis_pkg.
module mcis_filter_step
	import mcis_pkg::*;
(
	input  logic signed [ACC_W-1:0]  acc,
	input  logic                     primed,
	input  logic [SAMPLE_W-1:0]      sample,
	input  logic [GAIN_W-1:0]        gain,
	input  logic                     is_light,
	input  logic [SAMPLE_W-1:0]      dark_th,
	output logic signed [ACC_W-1:0]  acc_next,
	output logic signed [FILT_W-1:0] filt
);

	logic signed [26:0]       diff;
	logic signed [18:0]       step;
	logic [GAIN_W-1:0]        gain_sat;
	logic signed [28:0]       prod;
	logic signed [28:0]       sum;
	logic signed [ACC_W-1:0]  acc_upd;
	logic                     dark;

	always_comb begin
		// Gains above unity are saturated to unity.
		gain_sat = (gain > GAIN_ONE) ? GAIN_ONE : gain;
		// The sample is taken as signed once the channel is primed.
		diff     = {{3{sample[SAMPLE_W-1]}}, sample, 8'd0} - {acc[ACC_W-1], acc};
		step     = diff[26:8];	// arithmetic shift right by 8, i.e. floor division
		prod     = 29'(step * $signed({1'b0, gain_sat}));
		sum      = {{3{acc[ACC_W-1]}}, acc} + prod;
		acc_upd  = sum[ACC_W-1:0];
		dark     = is_light && (sample >= dark_th);

		if (!primed) begin
			if (dark) begin
				acc_next = '0;
				filt     = '0;
			end else begin
				acc_next = {2'b00, sample, 8'd0};
				filt     = {3'b000, sample};
			end
		end else begin
			acc_next = acc_upd;
			filt     = {acc_upd[ACC_W-1], acc_upd[ACC_W-1:8]} + FILT_W'(acc_upd[7]);
		end
	end

endmodule

// ===== rtl/core/mcis_light_step.sv =====
// Light percentage from a filtered light reading and the LED hysteresis.
// Depends on mcis_pkg.
module mcis_light_step
	import mcis_pkg::*;
(
	input  logic signed [FILT_W-1:0] filt,
	input  logic                     led,
	input  mcis_cfg_t                cfg,
	output logic [PCT_W-1:0]         pct,
	output logic                     led_next
);

	logic [17:0]        level;
	logic [24:0]        scaled;
	logic signed [16:0] lvl;

	always_comb begin
		level  = filt[FILT_W-1] ? '0 : filt[17:0];
		// times 100 as 64 + 32 + 4, then divide by 1024
		scaled = {1'b0, level, 6'd0} + {2'b00, level, 5'd0} + {5'b0, level, 2'd0};
		lvl    = $signed({2'b00, scaled[24:10]}) - $signed({10'd0, cfg.light_ofs});
		if (lvl < 0) begin
			pct = '0;
		end else if (lvl > $signed({10'd0, PCT_MAX})) begin
			pct = PCT_MAX;
		end else begin
			pct = lvl[PCT_W-1:0];
		end

		// Turning on takes precedence when both thresholds are met.
		if (pct < cfg.led_on) begin
			led_next = 1'b1;
		end else if (pct > cfg.led_off) begin
			led_next = 1'b0;
		end else begin
			led_next = led;
		end
	end

endmodule

// ===== rtl/core/multichannel_iir_sensor_conditioner.sv =====
// Top level of the multichannel IIR sensor conditioner.
// Depends on mcis_pkg, mcis_filter_step and mcis_light_step.
//
// Usage. Tagged ADC samples arrive as beats on the s_axis channel: the channel
// number travels in tuser and the raw 16-bit sample in tdata. Each beat on a
// channel in use yields exactly one result beat on m_axis, carrying the
// smoothed value and, for the ambient light channel, a clamped percentage and
// the LED state. Beats tagged with a channel that is not in use are dropped
// without a result and leave all state untouched.
// Configuration registers are written through the cfg channel, which always
// accepts; writes are only expected while no beats are in flight.
// An accepted input beat passes through the input register, then the
// accumulator read, update and light logic in a single pass into the output
// register. Throughput is one beat per cycle while the receiver does not stall,
// set by the per-channel accumulator read-modify-write, which finishes
// in the same cycle the result is captured, so consecutive beats on the same
// channel see each other's updates.
// Reset clears the configuration to its defaults, marks every channel as not
// yet primed and turns the LED off. When the receiver stalls, the output
// register holds its beat and the input register can still take one more
// beat, after which s_axis_tready falls until the output is taken.
module multichannel_iir_sensor_conditioner
	import mcis_pkg::*;
#(
	parameter int CHANNELS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	// Input stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [15:0]         s_axis_tdata,	// [15:0] sample
	input  logic [1:0]          s_axis_tuser,	// [1:0] channel
	// Result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [31:0]         m_axis_tdata,	// [16:0] filtered, [23:17] light_percent,
							// [24] led_lit, [31:25] zero
	output logic [2:0]          m_axis_tuser,	// [1:0] result_channel, [2] light_valid
	// Configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	// At most three channels are used, though the two-bit tag can name four.
	localparam int NUM_USED = (CHANNELS < 3) ? CHANNELS : 3;

	mcis_cfg_t cfg_q;

	logic                    valid_s1;
	logic [CHAN_W-1:0]       chan_s1;
	logic [SAMPLE_W-1:0]     sample_s1;

	logic                    valid_s2;
	logic [CHAN_W-1:0]       chan_s2;
	logic signed [OUT_W-1:0] filt_s2;
	logic [PCT_W-1:0]        pct_s2;
	logic                    light_s2;

	logic signed [ACC_W-1:0] acc_q [NUM_USED];
	logic [NUM_USED-1:0]     primed_q;
	logic                    led_q;

	logic                    advance;
	logic                    chan_ok;
	logic                    is_light;
	logic signed [ACC_W-1:0] acc_rd;
	logic                    primed_rd;
	logic [GAIN_W-1:0]       gain_sel;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [FILT_W-1:0] filt;
	logic [PCT_W-1:0]        pct;
	logic                    led_next;
	logic                    commit;

	// The input register moves on whenever the output register is free or drains.
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign chan_ok  = 32'(chan_s1) < NUM_USED;
	assign is_light = (chan_s1 == LIGHT_CHANNEL);
	assign commit   = valid_s1 && advance && chan_ok;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain0     <= RST_GAIN0;
			cfg_q.gain1     <= RST_GAIN1;
			cfg_q.gain2     <= RST_GAIN2;
			cfg_q.dark_th   <= RST_DARK_TH;
			cfg_q.light_ofs <= RST_LIGHT_OFS;
			cfg_q.led_on    <= RST_LED_ON;
			cfg_q.led_off   <= RST_LED_OFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAIN0:     cfg_q.gain0     <= cfg_data[GAIN_W-1:0];
				CFG_GAIN1:     cfg_q.gain1     <= cfg_data[GAIN_W-1:0];
				CFG_GAIN2:     cfg_q.gain2     <= cfg_data[GAIN_W-1:0];
				CFG_DARK_TH:   cfg_q.dark_th   <= cfg_data;
				CFG_LIGHT_OFS: cfg_q.light_ofs <= cfg_data[PCT_W-1:0];
				CFG_LED_ON:    cfg_q.led_on    <= cfg_data[PCT_W-1:0];
				CFG_LED_OFF:   cfg_q.led_off   <= cfg_data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			chan_s1   <= s_axis_tuser;
			sample_s1 <= s_axis_tdata;
		end
	end

	// Select the state and gain of the addressed channel.
	always_comb begin
		acc_rd    = '0;
		primed_rd = 1'b0;
		for (int i = 0; i < NUM_USED; i++) begin
			if (chan_s1 == CHAN_W'(i)) begin
				acc_rd    = acc_q[i];
				primed_rd = primed_q[i];
			end
		end
		case (chan_s1)
			2'd0:    gain_sel = cfg_q.gain0;
			2'd1:    gain_sel = cfg_q.gain1;
			default: gain_sel = cfg_q.gain2;
		endcase
	end

	mcis_filter_step u_filter (
		.acc      (acc_rd),
		.primed   (primed_rd),
		.sample   (sample_s1),
		.gain     (gain_sel),
		.is_light (is_light),
		.dark_th  (cfg_q.dark_th),
		.acc_next (acc_next),
		.filt     (filt)
	);

	mcis_light_step u_light (
		.filt     (filt),
		.led      (led_q),
		.cfg      (cfg_q),
		.pct      (pct),
		.led_next (led_next)
	);

	// Channel state is written back in the same cycle the result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= '0;
			led_q    <= 1'b0;
		end else if (commit) begin
			for (int i = 0; i < NUM_USED; i++) begin
				if (chan_s1 == CHAN_W'(i)) begin
					primed_q[i] <= 1'b1;
				end
			end
			if (is_light) begin
				led_q <= led_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < NUM_USED; i++) begin
				if (chan_s1 == CHAN_W'(i)) begin
					acc_q[i] <= acc_next;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && chan_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			chan_s2  <= chan_s1;
			filt_s2  <= filt[OUT_W-1:0];
			pct_s2   <= is_light ? pct : '0;
			light_s2 <= is_light;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, led_q, pct_s2, filt_s2};
	assign m_axis_tuser  = {light_s2, chan_s2};

	// A result never names a channel that is not in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tuser[1:0]) < NUM_USED))
		else $error("result beat carries a channel that is not in use");

	// The light flag marks exactly the light channel's results.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[1:0] == LIGHT_CHANNEL)))
		else $error("light flag does not match the result channel");

	// The percentage never leaves its clamped range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[23:17] <= PCT_MAX))
		else $error("light percentage above its maximum");

	// Only light channel updates may move the LED.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(commit && is_light) |=> $stable(led_q))
		else $error("LED changed without a light channel update");

	// A dropped beat produces no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !chan_ok) |=> !m_axis_tvalid)
		else $error("result produced for a dropped beat");

endmodule

// ===== dv/mcis_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the multichannel IIR sensor conditioner testbench.
// Watches the sample, result and register write channels, predicts every result beat
// from its own filter state and compares it field by field. Depends on mcis_pkg.
module mcis_result_checker
	import mcis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,	// [15:0] sample
	input  logic [1:0]  s_axis_tuser,	// [1:0] channel
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,	// [16:0] filtered, [23:17] light_percent, [24] led_lit
	input  logic [2:0]  m_axis_tuser,	// [1:0] result_channel, [2] light_valid
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatch_count,
	output int          results_pending
);

	localparam int FITTED_CHANNELS = 3;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [OUT_W-1:0]  filtered;
		logic [PCT_W-1:0]  percent;
		logic              percent_valid;
		logic              led;
	} conditioned_t;

	mcis_cfg_t               settings;
	logic signed [ACC_W-1:0] smooth_acc [FITTED_CHANNELS];
	logic                    primed [FITTED_CHANNELS];
	logic                    led_lit;
	conditioned_t            expected_results [$];
	int                      beat_number;

	// Advances the filter state of one channel by one sample and returns the result beat.
	function automatic conditioned_t condition_sample(input logic [CHAN_W-1:0] ch,
			input logic [SAMPLE_W-1:0] raw);
		conditioned_t            r;
		longint                  acc;
		longint                  diff;
		longint                  gain;
		longint                  level;
		longint                  pct;
		logic [GAIN_W-1:0]       gain_reg;
		logic signed [ACC_W-1:0] wrapped;
		acc = longint'(smooth_acc[ch]);
		if (!primed[ch]) begin
			if (ch == LIGHT_CHANNEL && raw >= settings.dark_th)
				acc = 0;
			else
				acc = longint'(raw) * 256;
			primed[ch] = 1'b1;
		end else begin
			gain_reg = (ch == 0) ? settings.gain0
					: (ch == 1) ? settings.gain1 : settings.gain2;
			gain = (gain_reg > 256) ? 256 : longint'(gain_reg);
			diff = longint'($signed(raw)) * 256 - acc;
			wrapped = ACC_W'(acc + (diff >>> 8) * gain);
			acc = longint'(wrapped);
		end
		smooth_acc[ch] = ACC_W'(acc);
		level = (acc >>> 8) + longint'(acc[7]);

		r = '0;
		r.chan = ch;
		r.filtered = OUT_W'(level);
		if (ch == LIGHT_CHANNEL) begin
			pct = (level < 0) ? 0 : level;
			pct = pct * 100 / 1024 - longint'(settings.light_ofs);
			if (pct > 100)
				pct = 100;
			if (pct < 0)
				pct = 0;
			r.percent = PCT_W'(pct);
			r.percent_valid = 1'b1;
			// Turning on takes precedence when both thresholds are crossed.
			if (r.percent < settings.led_on)
				led_lit = 1'b1;
			else if (r.percent > settings.led_off)
				led_lit = 1'b0;
		end
		r.led = led_lit;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input conditioned_t want,
			input conditioned_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display({"%0t: result beat %0d %s: expected ch %0d filt %0d pct %0d ",
					"valid %0d led %0d, got ch %0d filt %0d pct %0d valid %0d ",
					"led %0d tdata %h"},
				$time, beat_number, what, want.chan, $signed(want.filtered), want.percent,
				want.percent_valid, want.led, got.chan, $signed(got.filtered), got.percent,
				got.percent_valid, got.led, m_axis_tdata);
	endtask

	initial begin
		mismatch_count = 0;
		results_pending = 0;
		beat_number = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		conditioned_t want;
		conditioned_t got;
		if (!arst_n) begin
			settings.gain0 = 9'd160;
			settings.gain1 = 9'd160;
			settings.gain2 = 9'd4;
			settings.dark_th = 16'hFFF0;
			settings.light_ofs = 7'd20;
			settings.led_on = 7'd45;
			settings.led_off = 7'd55;
			for (int i = 0; i < FITTED_CHANNELS; i++) begin
				smooth_acc[i] = '0;
				primed[i] = 1'b0;
			end
			led_lit = 1'b0;
			expected_results.delete();
		end else begin
			// Results leave before new samples enter, as a sample cannot yield its result at the edge that accepts it.
			if (m_axis_tvalid && m_axis_tready) begin
				got.chan = m_axis_tuser[1:0];
				got.percent_valid = m_axis_tuser[2];
				got.filtered = m_axis_tdata[16:0];
				got.percent = m_axis_tdata[23:17];
				got.led = m_axis_tdata[24];
				if (expected_results.size() == 0) begin
					note_mismatch("with nothing expected", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want || m_axis_tdata[31:25] !== '0)
						note_mismatch("differs", want, got);
				end
				beat_number++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN0:     settings.gain0 = cfg_data[GAIN_W-1:0];
					CFG_GAIN1:     settings.gain1 = cfg_data[GAIN_W-1:0];
					CFG_GAIN2:     settings.gain2 = cfg_data[GAIN_W-1:0];
					CFG_DARK_TH:   settings.dark_th = cfg_data;
					CFG_LIGHT_OFS: settings.light_ofs = cfg_data[PCT_W-1:0];
					CFG_LED_ON:    settings.led_on = cfg_data[PCT_W-1:0];
					CFG_LED_OFF:   settings.led_off = cfg_data[PCT_W-1:0];
					default: ;
				endcase
			end
			// Samples tagged with a channel that is not fitted yield nothing.
			if (s_axis_tvalid && s_axis_tready && s_axis_tuser < FITTED_CHANNELS)
				expected_results.push_back(condition_sample(s_axis_tuser, s_axis_tdata));
		end
		results_pending = expected_results.size();
	end

endmodule

// ===== dv/multichannel_iir_sensor_conditioner_test.sv =====
`timescale 1ns / 1ps
// Top of the multichannel IIR sensor conditioner testbench: clock, reset, sample and
// register stimulus, and the verdict. Depends on mcis_pkg, the block and mcis_result_checker.
module multichannel_iir_sensor_conditioner_test
	import mcis_pkg::*;
();

	// The limit lies far above the length of the slowest correct run.
	localparam int CYCLE_LIMIT       = 200000;
	localparam int SETTING_COUNT     = 9;
	localparam int SAMPLES_PER_PHASE = 150;
	// A dropped beat can still sit in the input register once the last result is out.
	localparam int SETTLE_CYCLES     = 4;

	localparam logic [CHAN_W-1:0]   REF_CHANNEL         = 2'd0;
	localparam logic [CHAN_W-1:0]   THERM_CHANNEL       = 2'd1;
	localparam logic [CHAN_W-1:0]   UNUSED_CHANNEL      = 2'd3;
	localparam logic [2:0]          CFG_UNUSED          = 3'd7;
	localparam logic [SAMPLE_W-1:0] DARK_LEVEL_AT_RESET = 16'hFFF0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;	// [15:0] sample
	logic [1:0]  s_axis_tuser = '0;	// [1:0] channel
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;	// [16:0] filtered, [23:17] light_percent, [24] led_lit, [31:25] zero
	logic [2:0]  m_axis_tuser;	// [1:0] result_channel, [2] light_valid
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int mismatch_count;
	int results_pending;
	int cycle_count = 0;
	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int send_idle_pct = 19;
	int take_idle_pct = 69;

	multichannel_iir_sensor_conditioner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mcis_result_checker u_result_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	always #5 clk = ~clk;

	// The receiver decides afresh at every edge whether it will take a beat.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= take_idle_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one sample beat after a random number of idle cycles and returns at the edge
	// that accepts it. Valid stays high, so back-to-back beats need no extra step; each
	// idle cycle lowers it in a step of its own.
	task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= ch;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Lets the block run dry: every predicted result has come back and any dropped beat
	// still in the input register has drained.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every register in one burst, plus the unused index. Bits above a register's
	// width are filled at random, since the block must ignore them.
	task automatic program_filter(input int gain0, input int gain1, input int gain2,
			input int dark_level, input int offset, input int on_below, input int off_above);
		logic [15:0] values [8];
		values[CFG_GAIN0]     = {7'($urandom), 9'(gain0)};
		values[CFG_GAIN1]     = {7'($urandom), 9'(gain1)};
		values[CFG_GAIN2]     = {7'($urandom), 9'(gain2)};
		values[CFG_DARK_TH]   = 16'(dark_level);
		values[CFG_LIGHT_OFS] = {9'($urandom), 7'(offset)};
		values[CFG_LED_ON]    = {9'($urandom), 7'(on_below)};
		values[CFG_LED_OFF]   = {9'($urandom), 7'(off_above)};
		values[CFG_UNUSED]    = 16'($urandom);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= values[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Samples lean towards the extremes, and on the light channel towards the range in
	// which the percentage and the LED actually move.
	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [CHAN_W-1:0] ch);
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4, 5, 6: return (ch == LIGHT_CHANNEL) ? SAMPLE_W'($urandom_range(0, 2000))
					: SAMPLE_W'($urandom);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic run_random(input int count);
		logic [CHAN_W-1:0] ch;
		for (int n = 0; n < count; n++) begin
			// About one beat in twenty is tagged with the channel that is not fitted.
			ch = ($urandom_range(0, 19) == 0) ? UNUSED_CHANNEL : CHAN_W'($urandom_range(0, 2));
			send_sample(ch, pick_sample(ch));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset settings. Each channel is primed only once per
		// run, so the first light sample sits on one side of the dark threshold or the
		// other, chosen at random.
		send_sample(LIGHT_CHANNEL, $urandom_range(0, 1) ? DARK_LEVEL_AT_RESET
				: DARK_LEVEL_AT_RESET - 16'd1);
		send_sample(REF_CHANNEL, 16'hFFFF);
		send_sample(THERM_CHANNEL, 16'h0000);
		send_sample(UNUSED_CHANNEL, 16'hABCD);
		// Once primed, samples count as signed: the most negative and positive values.
		send_sample(REF_CHANNEL, 16'h8000);
		send_sample(REF_CHANNEL, 16'h7FFF);
		send_sample(REF_CHANNEL, 16'h0000);
		send_sample(THERM_CHANNEL, 16'hFFFF);
		send_sample(THERM_CHANNEL, 16'h8000);
		send_sample(THERM_CHANNEL, 16'h7FFF);
		send_sample(LIGHT_CHANNEL, 16'h0000);
		send_sample(LIGHT_CHANNEL, 16'h7FFF);
		send_sample(LIGHT_CHANNEL, 16'h7FFF);
		send_sample(UNUSED_CHANNEL, 16'h5555);
		send_sample(LIGHT_CHANNEL, 16'h8000);
		send_sample(LIGHT_CHANNEL, 16'h8000);
		send_sample(LIGHT_CHANNEL, 16'h0400);
		send_sample(REF_CHANNEL, 16'h1234);
		send_sample(THERM_CHANNEL, 16'hFEDC);
		send_sample(LIGHT_CHANNEL, 16'hFFFF);
		wait_quiet();

		for (int phase = 0; phase < SETTING_COUNT; phase++) begin
			// The sender and receiver swap their idling after a third of the settings,
			// and the last third runs at full rate on both sides.
			if (phase == SETTING_COUNT / 3) begin
				send_idle_pct = 69;
				take_idle_pct = 19;
			end
			if (phase == 2 * SETTING_COUNT / 3) begin
				send_idle_pct = 0;
				take_idle_pct = 0;
			end
			case (phase)
				// Full gain tracks the sample, so the light percentage spans its range.
				0: program_filter(256, 256, 256, 0, 0, 45, 55);
				// Zero gain freezes the filters; the widest offset and thresholds.
				1: program_filter(0, 0, 0, 16'hFFFF, 100, 0, 100);
				// Gains above one saturate; offset and thresholds beyond a hundred.
				2: program_filter(511, 300, 257, 16'h1234, 127, 127, 127);
				// Overlapping thresholds, where turning the LED on must win.
				3: program_filter(1, 2, 128, 16'h8000, 20, 60, 40);
				5: program_filter(160, 160, 4, 16'hFFF0, 20, 45, 55);
				// Never on from below, off as soon as the percentage is above zero.
				6: program_filter(256, 1, 256, 16'h0001, 0, 0, 0);
				8: program_filter(255, 129, 200, 16'h7FFF, 50, 30, 70);
				default: program_filter($urandom_range(0, 511), $urandom_range(0, 511),
						$urandom_range(0, 511), $urandom_range(0, 65535),
						$urandom_range(0, 127), $urandom_range(0, 127),
						$urandom_range(0, 127));
			endcase
			run_random(SAMPLES_PER_PHASE);
			wait_quiet();
		end

		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
